/* hw/rtl/rcs_pkg.sv */
// ----------------------------------------------------------------------------
// rcs_pkg: shared types and constants
// Sample widths, queue entry type and divider sizing for the contrast stretch.
// ----------------------------------------------------------------------------
package rcs_pkg;
  localparam int SampleBits = 16;
  localparam int ValBits    = 16;
  localparam int ProdBits   = SampleBits + ValBits;
  localparam int QDepth     = 2;
  localparam int QPtrBits   = $clog2(QDepth);

  typedef enum logic {
    OP_GATHER = 1'b0,
    OP_MAP    = 1'b1
  } op_e;

  // Ranges travel with each map item so the back end never sees later updates.
  typedef struct packed {
    logic [SampleBits-1:0] v;
    logic [SampleBits-1:0] lo;
    logic [SampleBits-1:0] hi;
  } chan_t;

  typedef struct packed {
    chan_t r;
    chan_t g;
    chan_t b;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } div_state_e;

  // How one channel's result is formed: by the divider, forced to zero, or
  // saturated to full scale.
  typedef enum logic [1:0] {
    CLS_DIVIDE,
    CLS_ZERO,
    CLS_FULL
  } cls_e;
endpackage

/* hw/rtl/rcs_front.sv */
// ----------------------------------------------------------------------------
// rcs_front: item intake
// Updates the min/max registers on gather items, queues map items with ranges.
// ----------------------------------------------------------------------------
module rcs_front import rcs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic                  operation_i,
  input  logic                  first_pixel_i,
  input  logic [SampleBits-1:0] red_in_i,
  input  logic [SampleBits-1:0] green_in_i,
  input  logic [SampleBits-1:0] blue_in_i,
  output logic                  job_valid_o,
  input  logic                  job_ready_i,
  output job_t                  job_o
);
  logic [SampleBits-1:0] lo_q [3];
  logic [SampleBits-1:0] hi_q [3];
  logic [SampleBits-1:0] smp [3];
  job_t                  mem_q [QDepth];
  logic [QPtrBits-1:0]   wp_q, rp_q;
  logic [QPtrBits:0]     cnt_q;
  logic                  acc, push, pop, full;

  assign smp[0] = red_in_i;
  assign smp[1] = green_in_i;
  assign smp[2] = blue_in_i;
  assign full   = (cnt_q == (QPtrBits+1)'(QDepth));
  assign ready_o = !full;
  assign acc    = valid_i && ready_o;
  assign push   = acc && (operation_i == OP_MAP);
  assign job_valid_o = (cnt_q != '0);
  assign pop    = job_valid_o && job_ready_i;
  assign job_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        lo_q[i] <= '0;
        hi_q[i] <= '0;
      end
    end else if (acc && operation_i == OP_GATHER) begin
      for (int i = 0; i < 3; i++) begin
        if (first_pixel_i || smp[i] < lo_q[i]) lo_q[i] <= smp[i];
        if (first_pixel_i || smp[i] > hi_q[i]) hi_q[i] <= smp[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop)  rp_q <= rp_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= '{r: '{v: red_in_i,   lo: lo_q[0], hi: hi_q[0]},
                       g: '{v: green_in_i, lo: lo_q[1], hi: hi_q[1]},
                       b: '{v: blue_in_i,  lo: lo_q[2], hi: hi_q[2]}};
    end
  end
endmodule

/* hw/rtl/rcs_back.sv */
// ----------------------------------------------------------------------------
// rcs_back: stretch engine
// Restoring division of (v-lo)*max_value by (hi-lo), three channels in lockstep.
// ----------------------------------------------------------------------------
module rcs_back import rcs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [ValBits-1:0]    max_value_i,
  input  logic                  job_valid_i,
  output logic                  job_ready_o,
  input  job_t                  job_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [SampleBits-1:0] red_out_o,
  output logic [SampleBits-1:0] green_out_o,
  output logic [SampleBits-1:0] blue_out_o
);
  localparam int CntBits = $clog2(ProdBits + 1);

  div_state_e            st_q, st_d;
  logic [CntBits-1:0]    cnt_q;
  logic [ProdBits-1:0]   num_q [3];
  logic [SampleBits:0]   rem_q [3];
  logic [SampleBits-1:0] den_q [3];
  cls_e                  cls_q [3];
  logic [SampleBits-1:0] res_q [3];
  chan_t                 ch [3];
  logic                  start, last;

  function automatic logic t_bit(logic [SampleBits:0] r, logic [ProdBits-1:0] n,
                                 logic [SampleBits-1:0] d);
    logic [SampleBits+1:0] t;
    t = {r, n[ProdBits-1]} - {2'b00, d};
    return t[SampleBits+1];
  endfunction

  assign ch[0] = job_i.r;
  assign ch[1] = job_i.g;
  assign ch[2] = job_i.b;
  assign job_ready_o = (st_q == ST_IDLE);
  assign start = job_valid_i && job_ready_o;
  assign last  = (cnt_q == CntBits'(ProdBits - 1));

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (start) st_d = ST_DIV;
      ST_DIV:  if (last) st_d = ST_OUT;
      ST_OUT:  if (ready_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    valid_o = (st_q == ST_OUT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      cnt_q <= '0;
    end else begin
      st_q <= st_d;
      if (start) cnt_q <= '0;
      else if (st_q == ST_DIV) cnt_q <= cnt_q + 1'b1;
    end
  end

  // The product is formed once at start; one quotient bit per cycle after.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (start) begin
        num_q[i] <= ProdBits'(ch[i].v - ch[i].lo) * ProdBits'(max_value_i);
        den_q[i] <= ch[i].hi - ch[i].lo;
        rem_q[i] <= '0;
        if (ch[i].hi <= ch[i].lo || ch[i].v <= ch[i].lo) cls_q[i] <= CLS_ZERO;
        else if (ch[i].v >= ch[i].hi)                    cls_q[i] <= CLS_FULL;
        else                                             cls_q[i] <= CLS_DIVIDE;
      end else if (st_q == ST_DIV) begin
        logic [SampleBits+1:0] t;
        t = {rem_q[i], num_q[i][ProdBits-1]} - {1'b0, 1'b0, den_q[i]};
        if (!t[SampleBits+1]) begin
          rem_q[i] <= t[SampleBits:0];
          num_q[i] <= {num_q[i][ProdBits-2:0], 1'b1};
        end else begin
          rem_q[i] <= {rem_q[i][SampleBits-1:0], num_q[i][ProdBits-1]};
          num_q[i] <= {num_q[i][ProdBits-2:0], 1'b0};
        end
      end
      if (st_q == ST_DIV && last) begin
        // Quotient is below max_value, so the low bits are exact.
        case (cls_q[i])
          CLS_ZERO: res_q[i] <= '0;
          CLS_FULL: res_q[i] <= max_value_i;
          default:  res_q[i] <= SampleBits'({num_q[i][ProdBits-2:0], 1'b0} |
                                ProdBits'(!t_bit(rem_q[i], num_q[i], den_q[i])));
        endcase
      end
    end
  end

  assign red_out_o   = res_q[0];
  assign green_out_o = res_q[1];
  assign blue_out_o  = res_q[2];
endmodule

/* hw/rtl/rgb_contrast_stretch_unit.sv */
// ----------------------------------------------------------------------------
// rgb_contrast_stretch_unit: per-channel min-max contrast stretch
// Gather items track channel ranges, map items return stretched pixels.
// ----------------------------------------------------------------------------
// A gather item (operation 0) updates the stored minimum and maximum of each
// channel; first_pixel loads them outright. It gives no result. A map item
// (operation 1) is queued with a snapshot of the ranges, so gather and map
// items may be mixed freely. The back end stretches each channel to
// floor((v-min)*max_value/(max-min)) with a restoring divider that yields one
// quotient bit per cycle over the 32-bit product; a map item holds the divider
// for a load, 32 steps and an output state kept until the result is taken,
// and the next load can start only in the cycle after that. Gather items run
// at one per cycle while the two-entry queue has room. Flat or inverted
// channels and samples at or below min give 0; samples at or above max give
// max_value. max_value is to be written only while idle; the block does not enforce it.
module rgb_contrast_stretch_unit import rcs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [ValBits-1:0]    cfg_wdata_i,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic                  operation_i,
  input  logic                  first_pixel_i,
  input  logic [SampleBits-1:0] red_in_i,
  input  logic [SampleBits-1:0] green_in_i,
  input  logic [SampleBits-1:0] blue_in_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [SampleBits-1:0] red_out_o,
  output logic [SampleBits-1:0] green_out_o,
  output logic [SampleBits-1:0] blue_out_o
);
  logic [ValBits-1:0] max_value_q;
  logic               job_valid, job_ready;
  job_t               job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_q <= ValBits'(255);
    end else if (cfg_we_i) begin
      max_value_q <= cfg_wdata_i;
    end
  end

  rcs_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .operation_i, .first_pixel_i,
    .red_in_i, .green_in_i, .blue_in_i,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  rcs_back u_back (
    .clk_i, .rst_ni, .max_value_i(max_value_q),
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .valid_o, .ready_i, .red_out_o, .green_out_o, .blue_out_o
  );
endmodule

/* hw/rtl/rcs_checker.sv */
// ----------------------------------------------------------------------------
// rcs_checker: port-level checks
// Watches the top level's ports for handshake and result sanity.
// ----------------------------------------------------------------------------
module rcs_checker import rcs_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  valid_o,
  input logic                  ready_i,
  input logic [SampleBits-1:0] red_out_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(red_out_o))
    else $error("result dropped or changed while stalled");

  a_out_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !$isunknown(red_out_o))
    else $error("result valid with unknown data");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !valid_o)
    else $error("result valid during reset");
endmodule

bind rgb_contrast_stretch_unit rcs_checker u_rcs_checker (
  .clk_i, .rst_ni, .valid_o, .ready_i, .red_out_o
);

/* sim/rgb_contrast_stretch_unit_tb.sv */
// ----------------------------------------------------------------------------
// rgb_contrast_stretch_unit_tb: self-checking bench for the contrast stretch
// Drives gather and map items, predicts stretched pixels and checks each one.
// ----------------------------------------------------------------------------
module rgb_contrast_stretch_unit_tb;
  import rcs_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [ValBits-1:0]    cfg_wdata_i;
  logic                  valid_i;
  logic                  ready_o;
  logic                  operation_i;
  logic                  first_pixel_i;
  logic [SampleBits-1:0] red_in_i;
  logic [SampleBits-1:0] green_in_i;
  logic [SampleBits-1:0] blue_in_i;
  logic                  valid_o;
  logic                  ready_i;
  logic [SampleBits-1:0] red_out_o;
  logic [SampleBits-1:0] green_out_o;
  logic [SampleBits-1:0] blue_out_o;

  // One stretched pixel as the block should return it.
  typedef struct packed {
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
  } pixel_t;

  // One row of the directed table. When has_pix is set the expected pixel is
  // typed in and must also agree with the predictor.
  typedef struct packed {
    op_e         op;
    logic        first;
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
    logic        has_pix;
    pixel_t      pix;
  } row_t;

  // Predictor state: the tracked channel ranges and the full-scale value.
  logic [15:0] full_scale;
  logic [15:0] lo_r, hi_r, lo_g, hi_g, lo_b, hi_b;

  pixel_t      pixels_due[$];
  pixel_t      typed_pixels[$];
  int          failures;
  int          maps_sent;

  rgb_contrast_stretch_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .valid_i       (valid_i),
    .ready_o       (ready_o),
    .operation_i   (operation_i),
    .first_pixel_i (first_pixel_i),
    .red_in_i      (red_in_i),
    .green_in_i    (green_in_i),
    .blue_in_i     (blue_in_i),
    .valid_o       (valid_o),
    .ready_i       (ready_i),
    .red_out_o     (red_out_o),
    .green_out_o   (green_out_o),
    .blue_out_o    (blue_out_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // The stretch of one channel with exact integer division. Flat or inverted
  // ranges and samples at or below the minimum give 0; samples at or above
  // the maximum saturate to the full-scale value.
  function automatic logic [15:0] stretch_sample(logic [15:0] v, logic [15:0] lo,
                                                 logic [15:0] hi);
    logic [31:0] num;
    logic [31:0] quo;
    if (hi <= lo || v <= lo) begin
      return 16'd0;
    end
    if (v >= hi) begin
      return full_scale;
    end
    num = 32'(v - lo) * 32'(full_scale);
    quo = num / 32'(hi - lo);
    return quo[15:0];
  endfunction

  // Applies one accepted item to the predictor; map items queue a pixel.
  task automatic track_or_stretch(op_e op, logic first, logic [15:0] r,
                                  logic [15:0] g, logic [15:0] b);
    pixel_t p;
    if (op == OP_GATHER) begin
      if (first) begin
        lo_r = r; hi_r = r; lo_g = g; hi_g = g; lo_b = b; hi_b = b;
      end else begin
        if (r < lo_r) lo_r = r;
        if (r > hi_r) hi_r = r;
        if (g < lo_g) lo_g = g;
        if (g > hi_g) hi_g = g;
        if (b < lo_b) lo_b = b;
        if (b > hi_b) hi_b = b;
      end
    end else begin
      p.r = stretch_sample(r, lo_r, hi_r);
      p.g = stretch_sample(g, lo_g, hi_g);
      p.b = stretch_sample(b, lo_b, hi_b);
      pixels_due.push_back(p);
      maps_sent++;
    end
  endtask

  // Sender: presents one item at the falling edge and holds it until it is
  // taken at a rising edge. The predictor is updated on acceptance.
  task automatic send_pixel(op_e op, logic first, logic [15:0] r, logic [15:0] g,
                            logic [15:0] b);
    valid_i       <= 1'b1;
    operation_i   <= op;
    first_pixel_i <= first;
    red_in_i      <= r;
    green_in_i    <= g;
    blue_in_i     <= b;
    do begin
      @(posedge clk_i);
    end while (!ready_o);
    track_or_stretch(op, first, r, g, b);
    @(negedge clk_i);
  endtask

  task automatic idle_sender(int cycles);
    valid_i <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Waits for every queued pixel, then gives the divider time to go quiet
  // before a register write or the end of the run.
  task automatic drain();
    valid_i <= 1'b0;
    while (pixels_due.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_full_scale(logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    full_scale  = value;
  endtask

  // A random sample, often pushed to the ends of its range.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  // One random image: a gather pass that starts with first_pixel, then a map
  // pass over the same pixels mixed with a few stray samples. Some images skip
  // the first pixel marker or set it in the map pass to reach the odd cases.
  task automatic send_image(int npix, inout int budget);
    logic [15:0] rs[$], gs[$], bs[$];
    logic        mark;
    int          gap;
    for (int i = 0; i < npix; i++) begin
      rs.push_back(pick_sample());
      gs.push_back(pick_sample());
      bs.push_back(pick_sample());
    end
    for (int i = 0; i < npix; i++) begin
      mark = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 30) == 0);
      send_pixel(OP_GATHER, mark, rs[i], gs[i], bs[i]);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      if (gap != 0) idle_sender(gap);
    end
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        send_pixel(OP_MAP, 1'($urandom), pick_sample(), pick_sample(), pick_sample());
      end else begin
        send_pixel(OP_MAP, 1'($urandom_range(0, 12) == 0), rs[i], gs[i], bs[i]);
      end
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
      if (gap != 0) idle_sender(gap);
    end
    budget -= 2 * npix;
  endtask

  // The receiver stalls on its own pattern: free-running stretches alternate
  // with stretches of random stalls.
  initial begin
    int phase;
    ready_i = 1'b0;
    phase   = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      phase++;
      if (phase[6]) begin
        ready_i <= 1'b1;
      end else begin
        ready_i <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  // Checker: compares every accepted pixel with the oldest prediction.
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && valid_o && ready_i) begin
      if (pixels_due.size() == 0) begin
        $error("unexpected pixel r=%0d g=%0d b=%0d", red_out_o, green_out_o,
               blue_out_o);
        failures++;
      end else begin
        want = pixels_due.pop_front();
        if (red_out_o !== want.r) begin
          $error("red_out: expected %0d, got %0d", want.r, red_out_o);
          failures++;
        end
        if (green_out_o !== want.g) begin
          $error("green_out: expected %0d, got %0d", want.g, green_out_o);
          failures++;
        end
        if (blue_out_o !== want.b) begin
          $error("blue_out: expected %0d, got %0d", want.b, blue_out_o);
          failures++;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    row_t        plan[$];
    int          budget;
    logic [15:0] scales[5];
    pixel_t      typed;
    pixel_t      pred;

    failures      = 0;
    maps_sent     = 0;
    full_scale    = 16'd255;
    lo_r = '0; hi_r = '0; lo_g = '0; hi_g = '0; lo_b = '0; hi_b = '0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    valid_i       = 1'b0;
    operation_i   = OP_GATHER;
    first_pixel_i = 1'b0;
    red_in_i      = '0;
    green_in_i    = '0;
    blue_in_i     = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table. Right after reset every range is flat at zero, so a
    // map item gives all zeros. A gather without first_pixel then widens the
    // reset ranges in place. The rest covers saturation on both sides, a
    // flat channel, first_pixel ignored in the map pass and full-range input.
    plan.push_back('{OP_MAP,    1'b0, 16'd100,  16'hFFFF, 16'd0,   1'b1, '{0, 0, 0}});
    plan.push_back('{OP_GATHER, 1'b0, 16'd200,  16'd10,   16'd50,  1'b0, '0});
    plan.push_back('{OP_MAP,    1'b0, 16'd200,  16'd0,    16'd50,  1'b1,
                     '{16'd255, 16'd0, 16'd255}});
    plan.push_back('{OP_MAP,    1'b0, 16'd100,  16'd5,    16'd25,  1'b0, '0});
    plan.push_back('{OP_GATHER, 1'b1, 16'd1000, 16'd7,    16'h0000, 1'b0, '0});
    plan.push_back('{OP_GATHER, 1'b0, 16'd3000, 16'd7,    16'hFFFF, 1'b0, '0});
    plan.push_back('{OP_GATHER, 1'b0, 16'd2000, 16'd7,    16'h8000, 1'b0, '0});
    plan.push_back('{OP_MAP,    1'b0, 16'd999,  16'd7,    16'h0000, 1'b1,
                     '{16'd0, 16'd0, 16'd0}});
    plan.push_back('{OP_MAP,    1'b1, 16'd3001, 16'd9,    16'hFFFF, 1'b1,
                     '{16'd255, 16'd0, 16'd255}});
    plan.push_back('{OP_MAP,    1'b0, 16'd2000, 16'd7,    16'h7FFF, 1'b0, '0});
    plan.push_back('{OP_MAP,    1'b1, 16'd1001, 16'd6,    16'h0001, 1'b0, '0});

    foreach (plan[i]) begin
      send_pixel(plan[i].op, plan[i].first, plan[i].r, plan[i].g, plan[i].b);
      if (plan[i].has_pix) begin
        typed = plan[i].pix;
        pred  = pixels_due[$];
        if (pred !== typed) begin
          $error("table row %0d: expected %h, predicted %h", i, typed, pred);
          failures++;
        end
      end
    end

    // Full-scale extremes, including zero, each followed by a short image.
    drain();
    scales = '{16'hFFFF, 16'd0, 16'd1, 16'd4095, 16'd255};
    foreach (scales[k]) begin
      write_full_scale(scales[k]);
      budget = 0;
      send_image(6, budget);
      drain();
    end

    // Random images of mostly small sizes; the full scale changes between
    // some of them while the block is idle. Before each change the sender waits
    // for every pending pixel.
    budget = 1800;
    while (budget > 0) begin
      send_image(($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                             : $urandom_range(1, 12), budget);
      if ($urandom_range(0, 5) == 0) begin
        drain();
        write_full_scale(($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                     : 16'($urandom_range(1, 65535)));
      end
    end

    drain();
    if (failures == 0 && pixels_due.size() == 0) begin
      $display("rgb_contrast_stretch_unit_tb: PASS");
    end else begin
      $display("rgb_contrast_stretch_unit_tb: FAIL");
    end
    $finish;
  end

  // Watchdog: a random budget of 1800 gather and map items plus stalls stays
  // far below this bound.
  initial begin
    #40000000;
    $display("rgb_contrast_stretch_unit_tb: FAIL");
    $finish;
  end
endmodule

/* files.f */
hw/rtl/rcs_pkg.sv
hw/rtl/rcs_front.sv
hw/rtl/rcs_back.sv
hw/rtl/rgb_contrast_stretch_unit.sv
hw/rtl/rcs_checker.sv
sim/rgb_contrast_stretch_unit_tb.sv
